@@ rtl/sha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and the round constant table of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  // Source of the byte that is shifted into the block register.
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      shift_en;
    byte_src_t byte_sel;
    logic [2:0] len_sel;
    logic      count_en;
    logic      comp_load;
    logic      round_en;
    logic [5:0] round_idx;
    logic      comp_fold;
    logic      h_init;
    logic [2:0] word_idx;
  } sha_cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ rtl/sha_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_datapath
// Block shift register, message schedule, round unit and chaining words.
// ----------------------------------------------------------------------------
module sha_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [7:0]       data_byte,
  output logic [31:0]      digest_word
);

  logic [511:0] blk;
  logic [31:0]  h [8];
  logic [31:0]  v [8];
  logic [63:0]  total;
  logic [63:0]  bits;
  logic [7:0]   sbyte;
  logic [31:0]  w0, w1, w9, w14, w_new, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Byte selection for the block register.
  assign bits = {total[60:0], 3'b000};
  always_comb begin
    case (cmd.byte_sel)
      sha_pkg::SRC_DATA: sbyte = data_byte;
      sha_pkg::SRC_PAD:  sbyte = sha_pkg::PAD_BYTE;
      sha_pkg::SRC_ZERO: sbyte = 8'h00;
      sha_pkg::SRC_LEN:  sbyte = bits[8 * (7 - cmd.len_sel) +: 8];
      default:           sbyte = 8'h00;
    endcase
  end

  // Schedule window taps; the oldest word sits at the top of the register.
  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];
  assign w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
               + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

  // Round functions.
  assign t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[cmd.round_idx] + w0;
  assign t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // Block register doubles as the schedule window during rounds.
  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk <= {blk[503:0], sbyte};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], w_new};
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (cmd.comp_load) begin
      for (int j = 0; j < 8; j++) v[j] <= h[j];
    end else if (cmd.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  // Chaining words and the message byte count.
  always_ff @(posedge clk) begin
    if (rst || cmd.h_init) begin
      for (int j = 0; j < 8; j++) h[j] <= sha_pkg::H_INIT[j];
      total <= 64'd0;
    end else begin
      if (cmd.comp_fold) begin
        for (int j = 0; j < 8; j++) h[j] <= h[j] + v[j];
      end
      if (cmd.count_en) begin
        total <= total + 64'd1;
      end
    end
  end

  assign digest_word = h[cmd.word_idx];

endmodule

@@ rtl/sha_control.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_control
// Sequencer for byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_stall,
  input  logic              byte_present,
  input  logic              end_of_message,
  output logic              dig_valid,
  input  logic              dig_stall,
  output logic [2:0]        word_index,
  output logic              final_word,
  output sha_pkg::sha_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD80, S_PADZ, S_LEN, S_LOAD, S_ROUND, S_FOLD, S_OUT
  } state_t;

  state_t     state;
  logic [5:0] fill;
  logic [5:0] round;
  logic [2:0] widx;
  logic       eom_pend, pad_done, len_done;
  logic       in_acc, out_acc, shifting;

  assign msg_stall  = (state != S_IDLE);
  assign dig_valid  = (state == S_OUT);
  assign in_acc     = msg_valid && !msg_stall;
  assign out_acc    = dig_valid && !dig_stall;
  assign word_index = widx;
  assign final_word = (widx == 3'd7);

  // Command decode.
  always_comb begin
    cmd = '0;
    cmd.byte_sel  = sha_pkg::SRC_DATA;
    cmd.len_sel   = fill[2:0];
    cmd.round_idx = round;
    cmd.word_idx  = widx;
    case (state)
      S_IDLE: begin
        cmd.shift_en = in_acc && byte_present;
        cmd.count_en = in_acc && byte_present;
      end
      S_PAD80: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = sha_pkg::SRC_PAD;
      end
      S_PADZ: begin
        cmd.shift_en = (fill != sha_pkg::LEN_POS);
        cmd.byte_sel = sha_pkg::SRC_ZERO;
      end
      S_LEN: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = sha_pkg::SRC_LEN;
      end
      S_LOAD:  cmd.comp_load = 1'b1;
      S_ROUND: cmd.round_en = 1'b1;
      S_FOLD:  cmd.comp_fold = 1'b1;
      S_OUT:   cmd.h_init = out_acc && (widx == 3'd7);
      default: ;
    endcase
  end

  assign shifting = cmd.shift_en;

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= 6'd0;
      round    <= 6'd0;
      widx     <= 3'd0;
      eom_pend <= 1'b0;
      pad_done <= 1'b0;
      len_done <= 1'b0;
    end else begin
      if (shifting) begin
        fill <= fill + 6'd1;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            eom_pend <= end_of_message;
            if (byte_present && fill == 6'd63) begin
              state <= S_LOAD;
            end else if (end_of_message) begin
              state <= S_PAD80;
            end
          end
        end
        S_PAD80: begin
          pad_done <= 1'b1;
          state    <= (fill == 6'd63) ? S_LOAD : S_PADZ;
        end
        S_PADZ: begin
          if (fill == sha_pkg::LEN_POS) begin
            state <= S_LEN;
          end else if (fill == 6'd63) begin
            state <= S_LOAD;
          end
        end
        S_LEN: begin
          if (fill == 6'd63) begin
            len_done <= 1'b1;
            state    <= S_LOAD;
          end
        end
        S_LOAD: begin
          round <= 6'd0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          if (len_done) begin
            widx  <= 3'd0;
            state <= S_OUT;
          end else if (!eom_pend) begin
            state <= S_IDLE;
          end else if (!pad_done) begin
            state <= S_PAD80;
          end else begin
            state <= S_PADZ;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            widx <= widx + 3'd1;
            if (widx == 3'd7) begin
              fill     <= 6'd0;
              eom_pend <= 1'b0;
              pad_done <= 1'b0;
              len_done <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/sha256_hasher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hasher_top
// Byte-serial SHA-256 engine: collects message bytes, pads, compresses and
// returns the digest as eight big-endian words.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  msg     | msg_valid/msg_stall  | data_byte, byte_present, end_of_message
//  dig     | dig_valid/dig_stall  | digest_word, word_index, final_word
//
// Message bytes are taken while msg_stall is low; the 64th byte of a block is
// followed by the load, 64 rounds of the single round unit and the fold into
// the hash words. An end mark adds pad bytes up to byte 63 (one or two blocks)
// and their compressions, then eight digest transactions.
// Reset is synchronous and loads the initial hash words.
// msg_stall is high whenever a block is being padded, compressed or output;
// a stalled digest transaction holds its word.
// ----------------------------------------------------------------------------
module sha256_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        dig_valid,
  input  logic        dig_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        final_word
);

  sha_pkg::sha_cmd_t cmd;

  sha_control u_control (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_stall      (msg_stall),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .dig_valid      (dig_valid),
    .dig_stall      (dig_stall),
    .word_index     (word_index),
    .final_word     (final_word),
    .cmd            (cmd)
  );

  sha_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .digest_word (digest_word)
  );

endmodule
